### hw/rtl/assert_macros.svh
// Assertion helpers used by the heightmap normal generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HMNG_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define HMNG_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/hmng_pkg.sv
`timescale 1ns / 1ps

package hmng_pkg;

    localparam logic [2:0] REG_WIDTH_IN_USE  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_IN_USE = 3'd1;
    localparam logic [2:0] REG_SPACING_X     = 3'd2;
    localparam logic [2:0] REG_SPACING_Y     = 3'd3;

    localparam logic [13:0] SCALE_SQ = 14'd16129;
    localparam logic [10:0] ROW_MAX  = 11'd1024;
    localparam logic [10:0] DIM_MIN  = 11'd3;

    typedef struct packed {
        logic start;
        logic accumulate;
    } mul_ctl_t;

endpackage

### hw/rtl/hmng_smul.sv
`timescale 1ns / 1ps

module hmng_smul
    import hmng_pkg::*;
#(
    parameter int PW = 100,
    parameter int BW = 40
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mul_ctl_t      ctl,
    input  logic [PW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          busy,
    output logic [PW-1:0] prod
);

    logic [PW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] acc_reg;
    logic          busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && b_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= ctl.accumulate ? acc_reg : '0;
        end
        else if (busy_reg && b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

### hw/rtl/heightmap_normal_generator.sv
`timescale 1ns / 1ps
// Heightmap normal generator.
// s_* : height samples of one tile in raster order, one per transfer.
// m_* : one transfer per interior pixel: normal x/y/z scaled to 127,
//       centre height, flipped output row, output column; tlast marks the
//       final interior pixel of the tile. Border pixels give no transfer.
// cfg_*: register writes (0 width, 1 height, 2 spacing x, 3 spacing y);
//       write only while the block is idle.
// A border sample goes back to idle after its reads. An interior sample
// is paced by the single shift-add multiplier, one operand bit per cycle,
// on magnitudes of at most HEIGHT_BITS+16 bits.
// Two line memories (registered read) hold the previous two rows; each
// sample reads its column, writes it back shifted, and reads column+1.
// Reset clears counters and control and loads register defaults of 256;
// line memories are not cleared. The result sits in an output register:
// a stalled receiver holds it, the next sample is still taken, and the
// block waits only when a second result is ready before the first left.
module heightmap_normal_generator
    import hmng_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int HEIGHT_BITS = 24
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [HEIGHT_BITS-1:0] height_sample, zero fill above
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // normal_x, normal_y, normal_z, centre_height, out_row, out_col
    output logic [((HEIGHT_BITS+50)/8)*8-1:0]       m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_index,
    input  logic [15:0]                            cfg_data
);

    `include "assert_macros.svh"

    localparam int HB  = HEIGHT_BITS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WSW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int MW  = HB + 16;
    localparam int MBW = (MW > 33) ? MW : 33;
    localparam int SW  = 2 * MBW + 2;
    localparam int PW  = SW + 14;
    localparam int OW  = ((HB + 50) / 8) * 8;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_RIGHT = 4'd2;
    localparam logic [3:0] ST_DIFF  = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_SQW   = 4'd5;
    localparam logic [3:0] ST_NSQ   = 4'd6;
    localparam logic [3:0] ST_NSQW  = 4'd7;
    localparam logic [3:0] ST_NSC   = 4'd8;
    localparam logic [3:0] ST_NSCW  = 4'd9;
    localparam logic [3:0] ST_TRY   = 4'd10;
    localparam logic [3:0] ST_TRYW  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]  state_reg;
    logic [10:0] width_reg, height_reg;
    logic [15:0] sx_reg, sy_reg;
    logic [CW-1:0] col_reg, cidx_reg;
    logic [9:0]  row_reg;

    logic signed [HB-1:0] down_reg, centre_reg, up_reg, left_reg, right_reg;
    logic                 inner_reg, lastpix_reg;
    logic [9:0]           orow_reg, ocol_reg;

    logic signed [MW:0] nx_reg, ny_reg;
    logic [MBW-1:0]     nz_reg;
    logic [SW-1:0]      s_reg;
    logic [PW-1:0]      num_reg;
    logic [1:0]         comp_reg;
    logic [6:0]         q_reg, bit_reg, qx_reg, qy_reg, qz_reg;

    logic          m_tvalid_reg, m_tlast_reg;
    logic [OW-1:0] m_tdata_reg;

    logic signed [HB-1:0] line_one_up [MAX_WIDTH];
    logic signed [HB-1:0] line_two_up [MAX_WIDTH];
    logic signed [HB-1:0] one_q_reg, two_q_reg;
    logic [CW-1:0]        one_raddr, right_idx;

    logic [WSW-1:0] w_ext, w_sat, c_ext;
    logic [10:0]    h_sat, r_ext;
    logic           s_fire, interior_next;

    logic signed [HB:0]    dx, dy;
    logic signed [HB+17:0] px, py;
    logic [31:0]           pz;
    logic [MW:0]           mag_x, mag_y;
    logic [MBW-1:0]        m_sel;
    logic [6:0]            t_try, q_next;
    logic [13:0]           tt;
    logic [7:0]            out_x, out_y;

    mul_ctl_t       mul_ctl;
    logic [PW-1:0]  mul_a;
    logic [MBW-1:0] mul_b;
    logic           mul_busy;
    logic [PW-1:0]  mul_prod;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign w_ext = WSW'(width_reg);
    assign w_sat = (w_ext < WSW'(3)) ? WSW'(3) :
                   ((w_ext > WSW'(MAX_WIDTH)) ? WSW'(MAX_WIDTH) : w_ext);
    assign h_sat = (height_reg < DIM_MIN) ? DIM_MIN :
                   ((height_reg > ROW_MAX) ? ROW_MAX : height_reg);
    assign c_ext = WSW'(col_reg);
    assign r_ext = {1'b0, row_reg};

    assign interior_next = (row_reg >= 10'd2) && (r_ext <= h_sat - 11'd1) &&
                           (col_reg != '0) && (c_ext <= w_sat - WSW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd256;
            height_reg <= 11'd256;
            sx_reg     <= 16'd256;
            sy_reg     <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH_IN_USE:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT_IN_USE: height_reg <= cfg_data[10:0];
                REG_SPACING_X:     sx_reg     <= cfg_data;
                REG_SPACING_Y:     sy_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // advance raster position on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_fire)
        begin
            if (c_ext + WSW'(1) >= w_sat)
            begin
                col_reg <= '0;
                row_reg <= (r_ext + 11'd1 >= h_sat) ? 10'd0 : row_reg + 10'd1;
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    assign right_idx = (cidx_reg == CW'(MAX_WIDTH - 1)) ? '0 : cidx_reg + CW'(1);
    assign one_raddr = (state_reg == ST_READ) ? right_idx : col_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            line_one_up[cidx_reg] <= down_reg;
            line_two_up[cidx_reg] <= one_q_reg;
        end
        one_q_reg <= line_one_up[one_raddr];
        two_q_reg <= line_two_up[col_reg];
    end

    assign dx    = {left_reg[HB-1], left_reg} - {right_reg[HB-1], right_reg};
    assign dy    = {up_reg[HB-1], up_reg} - {down_reg[HB-1], down_reg};
    assign px    = dx * $signed({1'b0, sy_reg});
    assign py    = dy * $signed({1'b0, sx_reg});
    assign pz    = sx_reg * sy_reg;
    assign mag_x = nx_reg[MW] ? (0 - nx_reg) : nx_reg;
    assign mag_y = ny_reg[MW] ? (0 - ny_reg) : ny_reg;

    always_comb
    begin
        case (comp_reg)
            2'd0:    m_sel = MBW'(mag_x[MW-1:0]);
            2'd1:    m_sel = MBW'(mag_y[MW-1:0]);
            default: m_sel = nz_reg;
        endcase
    end

    assign t_try  = q_reg | bit_reg;
    assign tt     = t_try * t_try;
    assign q_next = (mul_prod <= num_reg) ? t_try : q_reg;

    always_comb
    begin
        mul_ctl.start      = 1'b0;
        mul_ctl.accumulate = 1'b0;
        mul_a              = PW'(m_sel);
        mul_b              = m_sel;
        case (state_reg)
            ST_SQ:
            begin
                mul_ctl.start      = 1'b1;
                mul_ctl.accumulate = (comp_reg != 2'd0);
            end
            ST_NSQ:
            begin
                mul_ctl.start = 1'b1;
            end
            ST_NSC:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = mul_prod;
                mul_b         = MBW'(SCALE_SQ);
            end
            ST_TRY:
            begin
                mul_ctl.start = 1'b1;
                mul_a         = PW'(s_reg);
                mul_b         = MBW'(tt);
            end
            default: ;
        endcase
    end

    hmng_smul #(
        .PW (PW),
        .BW (MBW)
    ) u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= 2'd0;
            bit_reg   <= 7'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:  state_reg <= ST_RIGHT;
                ST_RIGHT: state_reg <= inner_reg ? ST_DIFF : ST_IDLE;
                ST_DIFF:
                begin
                    comp_reg  <= 2'd0;
                    state_reg <= ST_SQ;
                end
                ST_SQ:    state_reg <= ST_SQW;
                ST_SQW:
                begin
                    if (!mul_busy)
                    begin
                        if (comp_reg == 2'd2)
                        begin
                            comp_reg  <= 2'd0;
                            state_reg <= (mul_prod == '0) ? ST_OUT : ST_NSQ;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_NSQ:   state_reg <= ST_NSQW;
                ST_NSQW:
                begin
                    if (!mul_busy)
                    begin
                        state_reg <= ST_NSC;
                    end
                end
                ST_NSC:   state_reg <= ST_NSCW;
                ST_NSCW:
                begin
                    if (!mul_busy)
                    begin
                        bit_reg   <= 7'b1000000;
                        state_reg <= ST_TRY;
                    end
                end
                ST_TRY:   state_reg <= ST_TRYW;
                ST_TRYW:
                begin
                    if (!mul_busy)
                    begin
                        bit_reg <= bit_reg >> 1;
                        if (bit_reg[0])
                        begin
                            if (comp_reg == 2'd2)
                            begin
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                comp_reg  <= comp_reg + 2'd1;
                                state_reg <= ST_NSQ;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_TRY;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            down_reg    <= $signed(s_tdata[HB-1:0]);
            cidx_reg    <= col_reg;
            inner_reg   <= interior_next;
            lastpix_reg <= (r_ext == h_sat - 11'd1) && (c_ext == w_sat - WSW'(2));
            orow_reg    <= 10'(h_sat - 11'd1 - r_ext);
            ocol_reg    <= 10'(c_ext - WSW'(1));
        end
        if (state_reg == ST_READ)
        begin
            centre_reg <= one_q_reg;
            up_reg     <= two_q_reg;
            left_reg   <= centre_reg;
        end
        if (state_reg == ST_RIGHT)
        begin
            right_reg <= one_q_reg;
        end
        if (state_reg == ST_DIFF)
        begin
            nx_reg <= px[MW:0];
            ny_reg <= py[MW:0];
            nz_reg <= MBW'({pz, 1'b0});
        end
        if (state_reg == ST_SQW && !mul_busy && comp_reg == 2'd2)
        begin
            s_reg  <= mul_prod[SW-1:0];
            qx_reg <= 7'd0;
            qy_reg <= 7'd0;
            qz_reg <= 7'd0;
        end
        if (state_reg == ST_NSCW && !mul_busy)
        begin
            num_reg <= mul_prod;
            q_reg   <= 7'd0;
        end
        if (state_reg == ST_TRYW && !mul_busy)
        begin
            q_reg <= bit_reg[0] ? 7'd0 : q_next;
            if (bit_reg[0])
            begin
                case (comp_reg)
                    2'd0:    qx_reg <= q_next;
                    2'd1:    qy_reg <= q_next;
                    default: qz_reg <= q_next;
                endcase
            end
        end
    end

    assign out_x = nx_reg[MW] ? (8'd0 - {1'b0, qx_reg}) : {1'b0, qx_reg};
    assign out_y = ny_reg[MW] ? (8'd0 - {1'b0, qy_reg}) : {1'b0, qy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= OW'({ocol_reg, orow_reg, centre_reg, qz_reg, out_y, out_x});
            m_tlast_reg <= lastpix_reg;
        end
    end

    `HMNG_ASSERT_NXT(a_accept_reads, s_fire, state_reg == ST_READ)
    `HMNG_ASSERT_IMP(a_mul_free, mul_ctl.start, !mul_busy)
    `HMNG_ASSERT_IMP(a_bit_onehot, 1'b1, $onehot0(bit_reg))
    `HMNG_ASSERT_NXT(a_out_hold, state_reg == ST_OUT && m_tvalid_reg && !m_tready,
                     state_reg == ST_OUT && m_tvalid_reg)

endmodule
